>>> rtl/core/vr2d_pkg.sv
// Shared constants for the 2D refraction pipeline.
// Used by vector_refract_2d; no dependencies.
package vr2d_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int RAD_W     = 64;
  localparam int CW        = 35;
  localparam int IN_TDATA_W  = 5 * DATA_W;
  localparam int OUT_TDATA_W = 2 * DATA_W;

endpackage

>>> rtl/core/vr2d_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side payload alongside each radicand; depends on nothing else.
module vr2d_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int N   = IN_W / 2;
  localparam int RMW = N + 2;

  logic [RMW-1:0]    rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [IN_W-1:0]   rad_r  [N];
  logic [SIDE_W-1:0] side_r [N];
  logic              vld_r  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [RMW-1:0]    rem_p;
    logic [N-1:0]      root_p;
    logic [IN_W-1:0]   rad_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [RMW+1:0]    rem_sh;
    logic [RMW+1:0]    trial;
    logic              ge;
    logic [RMW-1:0]    rem_nxt;
    logic [N-1:0]      root_nxt;
    logic [IN_W-1:0]   rad_nxt;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
      assign side_p = in_side;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign rad_p  = rad_r[g-1];
      assign side_p = side_r[g-1];
      assign vld_p  = vld_r[g-1];
    end

    assign rem_sh   = {rem_p, rad_p[IN_W-1 -: 2]};
    assign trial    = {2'b00, root_p, 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_nxt  = ge ? RMW'(rem_sh - trial) : rem_sh[RMW-1:0];
    assign root_nxt = {root_p[N-2:0], ge};
    assign rad_nxt  = {rad_p[IN_W-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_p;
      end
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= rad_nxt;
        side_r[g] <= side_p;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

>>> rtl/core/vector_refract_2d.sv
// Top level of the 2D refraction block: stream ports and the fixed point pipeline.
// Depends on vr2d_pkg and on the pipelined square root vr2d_isqrt.
//
// Usage: an incident vector, a surface normal and the ratio eta arrive on the
// in_ channel, one transfer per item; each item gives exactly one transfer on the
// out_ channel with the refracted vector in out_tdata and the total internal
// reflection flag in out_tuser. Items leave in the order they arrived.
// From the input transfer to the output valid an item passes six stages
// of products and rounding, 32 square root stages (one root bit each), two
// stages for the final products and the output register.
// Throughput is one item per cycle while the receiver does not stall; the 32 bit
// square root pipeline and the multipliers take a new operand whenever it advances.
// The whole pipeline advances together whenever the output register is empty
// or is being taken, so in_tready follows out_tready while the output holds
// data. When the receiver stalls, every stage holds its contents and nothing
// is lost or repeated.
// A synchronous reset clears all valid bits; data registers are not cleared.
module vector_refract_2d #(
  parameter int FRAC_BITS = vr2d_pkg::FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // inc_x [15:0], inc_y [31:16], norm_x [47:32], norm_y [63:48], ratio [79:64]
  input  logic [vr2d_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_x [15:0], out_y [31:16]
  output logic [vr2d_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // total_reflect [0]
  output logic                              out_tuser
);

  localparam int F      = FRAC_BITS;
  localparam int XW     = 66;
  localparam int DW     = 34 - F;
  localparam int EW     = 33 - F;
  localparam int TW     = (((63 - 3 * F) > F) ? (63 - 3 * F) : F) + 3;
  localparam int TH     = TW - 16;
  localparam int CW     = vr2d_pkg::CW;
  localparam int RAD_W  = vr2d_pkg::RAD_W;
  localparam int SW     = RAD_W / 2;
  localparam int SIDE_W = 4 * 16 + 16 + CW + 1;

  localparam logic signed [XW-1:0] HALF   = XW'(1) <<< (F - 1);
  localparam logic signed [XW-1:0] ONE2   = XW'(1) <<< (2 * F);
  localparam logic signed [XW-1:0] SAT_HI = XW'(32767);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  typedef struct packed {
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic        [15:0] eta;
  } vec_t;

  function automatic logic [15:0] sat16(input logic signed [XW-1:0] v);
    logic [15:0] r;
    if (v > SAT_HI) begin
      r = 16'h7fff;
    end else if (v < SAT_LO) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic adv;
  vec_t in_vec;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_vec.ix  = in_tdata[15:0];
  assign in_vec.iy  = in_tdata[31:16];
  assign in_vec.nx  = in_tdata[47:32];
  assign in_vec.ny  = in_tdata[63:48];
  assign in_vec.eta = in_tdata[79:64];

  // Stage 1: dot product terms and eta squared.
  logic               s1_vld_r;
  vec_t               s1_vec_r;
  logic signed [31:0] s1_px_r, s1_py_r;
  logic        [31:0] s1_e2f_r;

  // Stage 2: d and e2 rounded.
  logic                 s2_vld_r;
  vec_t                 s2_vec_r;
  logic signed [DW-1:0] s2_d_r;
  logic        [EW-1:0] s2_e2_r;
  logic signed [XW-1:0] s2_dsum;
  logic signed [XW-1:0] s2_esum;

  // Stage 3: d squared and eta times d.
  logic                     s3_vld_r;
  vec_t                     s3_vec_r;
  logic signed [2*DW-1:0]   s3_dd_r;
  logic signed [DW+16:0]    s3_edf_r;
  logic        [EW-1:0]     s3_e2_r;

  // Stage 4: t and the rounded eta times d.
  logic                 s4_vld_r;
  vec_t                 s4_vec_r;
  logic signed [TW-1:0] s4_t_r;
  logic signed [CW-1:0] s4_ed_r;
  logic        [EW-1:0] s4_e2_r;
  logic signed [XW-1:0] s4_tsum;
  logic signed [XW-1:0] s4_esum;

  // Stage 5: e2 times t in two partial products.
  logic                       s5_vld_r;
  vec_t                       s5_vec_r;
  logic signed [CW-1:0]       s5_ed_r;
  logic signed [EW+17:0]      s5_plo_r;
  logic signed [EW+TH:0]      s5_phi_r;

  // Stage 6: k, the reflection flag and the radicand.
  logic                 s6_vld_r;
  vec_t                 s6_vec_r;
  logic signed [CW-1:0] s6_ed_r;
  logic                 s6_tir_r;
  logic [RAD_W-1:0]     s6_rad_r;
  logic signed [XW-1:0] s6_k;

  always_comb begin
    s2_dsum = XW'(s1_px_r) + XW'(s1_py_r) + HALF;
    s2_esum = XW'($signed({1'b0, s1_e2f_r})) + HALF;
    s4_tsum = ONE2 - XW'(s3_dd_r) + HALF;
    s4_esum = XW'(s3_edf_r) + HALF;
    s6_k    = ONE2 - ((XW'(s5_phi_r) <<< 16) + XW'(s5_plo_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
    if (adv) begin
      s1_vec_r <= in_vec;
      s1_px_r  <= in_vec.nx * in_vec.ix;
      s1_py_r  <= in_vec.ny * in_vec.iy;
      s1_e2f_r <= in_vec.eta * in_vec.eta;

      s2_vec_r <= s1_vec_r;
      s2_d_r   <= DW'(s2_dsum >>> F);
      s2_e2_r  <= EW'(s2_esum >>> F);

      s3_vec_r <= s2_vec_r;
      s3_dd_r  <= s2_d_r * s2_d_r;
      s3_edf_r <= $signed({1'b0, s2_vec_r.eta}) * s2_d_r;
      s3_e2_r  <= s2_e2_r;

      s4_vec_r <= s3_vec_r;
      s4_t_r   <= TW'(s4_tsum >>> F);
      s4_ed_r  <= CW'(s4_esum >>> F);
      s4_e2_r  <= s3_e2_r;

      s5_vec_r <= s4_vec_r;
      s5_ed_r  <= s4_ed_r;
      s5_plo_r <= $signed({1'b0, s4_e2_r}) * $signed({1'b0, s4_t_r[15:0]});
      s5_phi_r <= $signed({1'b0, s4_e2_r}) * $signed(s4_t_r[TW-1:16]);

      s6_vec_r <= s5_vec_r;
      s6_ed_r  <= s5_ed_r;
      s6_tir_r <= s6_k[XW-1];
      s6_rad_r <= s6_k[XW-1] ? '0 : s6_k[RAD_W-1:0];
    end
  end

  // Square root of k, with the item's data carried alongside.
  logic              sq_vld;
  logic [SW-1:0]     sq_root;
  logic [SIDE_W-1:0] sq_side_in, sq_side;
  vec_t              sq_vec;
  logic signed [CW-1:0] sq_ed;
  logic              sq_tir;

  assign sq_side_in = {s6_tir_r, s6_ed_r, s6_vec_r};
  assign {sq_tir, sq_ed, sq_vec} = sq_side;

  vr2d_isqrt #(
    .IN_W   (RAD_W),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s6_vld_r),
    .in_rad    (s6_rad_r),
    .in_side   (sq_side_in),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage A: c = round(eta*d) + sqrt(k).
  logic                 sa_vld_r;
  vec_t                 sa_vec_r;
  logic                 sa_tir_r;
  logic signed [CW-1:0] sa_c_r;

  // Stage B: the four final products.
  logic                    sb_vld_r;
  logic                    sb_tir_r;
  logic signed [CW+15:0]   sb_mx_r, sb_my_r;
  logic signed [32:0]      sb_ex_r, sb_ey_r;

  logic signed [XW-1:0] vx, vy;
  logic                 out_tvalid_r;
  logic [31:0]          out_tdata_r;
  logic                 out_tuser_r;

  always_comb begin
    vx = (XW'(sb_ex_r) - XW'(sb_mx_r) + HALF) >>> F;
    vy = (XW'(sb_ey_r) - XW'(sb_my_r) + HALF) >>> F;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r     <= 1'b0;
      sb_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      sa_vld_r     <= sq_vld;
      sb_vld_r     <= sa_vld_r;
      out_tvalid_r <= sb_vld_r;
    end
    if (adv) begin
      sa_vec_r <= sq_vec;
      sa_tir_r <= sq_tir;
      sa_c_r   <= sq_ed + CW'($signed({1'b0, sq_root}));

      sb_tir_r <= sa_tir_r;
      sb_mx_r  <= sa_c_r * sa_vec_r.nx;
      sb_my_r  <= sa_c_r * sa_vec_r.ny;
      sb_ex_r  <= $signed({1'b0, sa_vec_r.eta}) * sa_vec_r.ix;
      sb_ey_r  <= $signed({1'b0, sa_vec_r.eta}) * sa_vec_r.iy;

      out_tuser_r <= sb_tir_r;
      out_tdata_r <= sb_tir_r ? '0 : {sat16(vy), sat16(vx)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
